@@ hw/rtl/dlc_pkg.sv @@
// Shared types and constants for the door lock controller.
`default_nettype none

package dlc_pkg;

  localparam int unsigned TimerBits = 16;
  localparam int unsigned CfgBits   = 16;
  localparam int unsigned CmpBits   = (TimerBits > CfgBits) ? TimerBits : CfgBits;

  localparam int unsigned InDataBits  = 8;
  localparam int unsigned OutDataBits = 8;

  localparam logic RegAutoLockDelay = 1'b0;
  localparam logic RegBlinkInterval = 1'b1;

  typedef enum logic [1:0] {
    ModeTick   = 2'd0,
    ModeUnlock = 2'd1,
    ModeLock   = 2'd2
  } mode_e;

  typedef struct packed {
    logic tamper_flag;
    logic door_is_open;
    logic is_locked;
    logic led_on;
    logic relay_on;
  } dlc_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/dlc_core.sv @@
// Lock state registers and the per-item next-state logic.
`default_nettype none

module dlc_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_en_i,
  input  wire logic [1:0]                     mode_i,
  input  wire logic                           door_sample_i,
  input  wire logic [dlc_pkg::CfgBits-1:0]    auto_lock_delay_i,
  input  wire logic [dlc_pkg::CfgBits-1:0]    blink_interval_i,
  output dlc_pkg::dlc_status_t                status_d_o
);
  import dlc_pkg::*;

  logic                 locked_q, locked_d;
  logic                 door_q, door_d;
  logic                 tamper_q, tamper_d;
  logic                 blink_en_q, blink_en_d;
  logic                 led_q, led_d;
  logic [TimerBits-1:0] unlock_el_q, unlock_el_d;
  logic [TimerBits-1:0] blink_el_q, blink_el_d;

  always_comb begin
    locked_d    = locked_q;
    door_d      = door_q;
    tamper_d    = tamper_q;
    blink_en_d  = blink_en_q;
    led_d       = led_q;
    unlock_el_d = unlock_el_q;
    blink_el_d  = blink_el_q;
    case (mode_i)
      ModeTick: begin
        unlock_el_d = (&unlock_el_q) ? unlock_el_q : unlock_el_q + 1'b1;
        blink_el_d  = (&blink_el_q) ? blink_el_q : blink_el_q + 1'b1;
        if (blink_en_q &&
            (CmpBits'(blink_el_d) >= CmpBits'(blink_interval_i))) begin
          blink_el_d = '0;
          led_d      = ~led_q;
        end
        if (door_sample_i != door_q) begin
          door_d = door_sample_i;
          if (door_sample_i && locked_q) begin
            tamper_d = 1'b1;
          end
          if (!door_sample_i && !locked_q) begin
            locked_d   = 1'b1;
            blink_en_d = 1'b1;
          end
        end
        if (!locked_d && (CmpBits'(unlock_el_d) >= CmpBits'(auto_lock_delay_i))) begin
          locked_d   = 1'b1;
          blink_en_d = 1'b1;
        end
      end
      ModeUnlock: begin
        if (locked_q) begin
          locked_d   = 1'b0;
          tamper_d   = 1'b0;
          blink_en_d = 1'b0;
          led_d      = 1'b1;
        end
        unlock_el_d = '0;
      end
      ModeLock: begin
        if (!locked_q) begin
          locked_d   = 1'b1;
          blink_en_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q    <= 1'b1;
      door_q      <= 1'b0;
      tamper_q    <= 1'b0;
      blink_en_q  <= 1'b0;
      led_q       <= 1'b0;
      unlock_el_q <= '0;
      blink_el_q  <= '0;
    end else if (step_en_i) begin
      locked_q    <= locked_d;
      door_q      <= door_d;
      tamper_q    <= tamper_d;
      blink_en_q  <= blink_en_d;
      led_q       <= led_d;
      unlock_el_q <= unlock_el_d;
      blink_el_q  <= blink_el_d;
    end
  end

  assign status_d_o = '{
    tamper_flag:  tamper_d,
    door_is_open: door_d,
    is_locked:    locked_d,
    led_on:       led_d,
    relay_on:     ~locked_d
  };

`ifndef NO_ASSERTIONS
  a_tamper_only_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tamper_q |-> locked_q) else $error("tamper flag set while unlocked");

  a_blink_only_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_en_q |-> locked_q) else $error("blinking enabled while unlocked");

  a_unlock_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && mode_i == ModeUnlock) |=> (!locked_q && unlock_el_q == '0))
    else $error("unlock did not release and restart the delay");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/door_lock_controller.sv @@
// Top level of the door lock controller: stream ports, configuration and stages.
`default_nettype none

// Each transfer on the slave side is a one-millisecond tick with the reed switch
// sample, an unlock command or a lock command, and yields exactly one status
// transfer on the master side. Items pass an input register, combinational
// next-state logic and a result register, so the block takes one item per cycle
// unless the master side stalls; the single state update per item sets that rate.
// Configuration writes are taken at any time but are meant for idle periods.
module door_lock_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_addr_i,
  input  wire logic [dlc_pkg::CfgBits-1:0]   cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: mode[1:0], door_sample[2], zero fill.
  input  wire logic [dlc_pkg::InDataBits-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // Fields from bit 0: relay_on, led_on, is_locked, door_is_open, tamper_flag, zero fill.
  output logic [dlc_pkg::OutDataBits-1:0]    m_axis_tdata
);
  import dlc_pkg::*;

  logic [CfgBits-1:0] auto_lock_delay_q;
  logic [CfgBits-1:0] blink_interval_q;

  logic               in_vld_q;
  logic [1:0]         in_mode_q;
  logic               in_door_q;
  logic               out_vld_q;
  dlc_status_t        out_stat_q;
  dlc_status_t        stat_d;
  logic               adv;
  logic               in_take;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_lock_delay_q <= CfgBits'(5000);
      blink_interval_q  <= CfgBits'(500);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegAutoLockDelay: auto_lock_delay_q <= cfg_wdata_i;
        RegBlinkInterval: blink_interval_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_mode_q <= s_axis_tdata[1:0];
      in_door_q <= s_axis_tdata[2];
    end
    if (adv) begin
      out_stat_q <= stat_d;
    end
  end

  dlc_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_en_i         (adv),
    .mode_i            (in_mode_q),
    .door_sample_i     (in_door_q),
    .auto_lock_delay_i (auto_lock_delay_q),
    .blink_interval_i  (blink_interval_q),
    .status_d_o        (stat_d)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_stat_q.tamper_flag, out_stat_q.door_is_open,
                          out_stat_q.is_locked, out_stat_q.led_on, out_stat_q.relay_on};

`ifndef NO_ASSERTIONS
  a_relay_vs_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_stat_q.relay_on != out_stat_q.is_locked))
    else $error("relay and lock state disagree");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q) else $error("advanced item missing from result register");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(in_mode_q) && $stable(in_door_q)))
    else $error("stalled input item lost");
`endif

endmodule

`default_nettype wire
